### rtl/pkrs_pkg.sv
// Shared types, constants and the record-count function of the PKCS#7 record segmenter.
// Used by the controller, the datapath and the top level.
`default_nettype none

package pkrs_pkg;

  // Record geometry
  localparam logic [4:0] BODY_BYTES = 5'd17;

  // Input kinds carried on s_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic REG_TYPE   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  // floor(x/17) for 13-bit x as (x * 61681) >> 20
  localparam logic [15:0] RECIP_17   = 16'd61681;
  localparam int          RECIP_SHIFT = 20;

  // Kind of byte placed on the output
  typedef enum logic [2:0] {
    EK_TYPE,
    EK_COUNT,
    EK_INDEX,
    EK_DATA,
    EK_PAD
  } emit_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       emit;
    emit_kind_t kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
    logic len_zero;
    logic offset_zero;
    logic done;
    logic wrap;
    logic pad_last;
    logic slot_free;
  } dp_status_t;

  // Record count byte: floor(len/17)+1, low 8 bits
  function automatic logic [7:0] rec_count_of(input logic [12:0] len);
    logic [28:0] prod;
    logic [8:0]  quot;
    prod = {16'd0, len} * {13'd0, RECIP_17};
    quot = prod[RECIP_SHIFT +: 9];
    return quot[7:0] + 8'd1;
  endfunction

endpackage

`default_nettype wire

### rtl/pkrs_ctrl.sv
// Controller state machine of the PKCS#7 record segmenter: sequences header,
// data and padding bytes. Depends on pkrs_pkg.
`default_nettype none

module pkrs_ctrl
  import pkrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic       s_op,
  output logic            s_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TYPE,
    S_COUNT,
    S_INDEX,
    S_DATA,
    S_PAD
  } state_t;

  state_t state;
  logic   hdr_to_pad;
  logic   accept;
  logic   emit;

  // Take a request only when no byte sequence is running
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign emit     = (state != S_IDLE) && status.slot_free;

  // Map state to the byte kind to emit
  always_comb begin
    cmd.accept = accept;
    cmd.emit   = emit;
    case (state)
      S_TYPE:  cmd.kind = EK_TYPE;
      S_COUNT: cmd.kind = EK_COUNT;
      S_INDEX: cmd.kind = EK_INDEX;
      S_DATA:  cmd.kind = EK_DATA;
      S_PAD:   cmd.kind = EK_PAD;
      default: cmd.kind = EK_TYPE;
    endcase
  end

  // Advance one byte per free output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hdr_to_pad <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_op == OP_START) begin
              if (status.len_zero) begin
                state      <= S_TYPE;
                hdr_to_pad <= 1'b1;
              end
            end else if (status.busy) begin
              hdr_to_pad <= 1'b0;
              state      <= status.offset_zero ? S_TYPE : S_DATA;
            end
          end
        end
        S_TYPE: begin
          if (emit) state <= S_COUNT;
        end
        S_COUNT: begin
          if (emit) state <= S_INDEX;
        end
        S_INDEX: begin
          if (emit) state <= hdr_to_pad ? S_PAD : S_DATA;
        end
        S_DATA: begin
          if (emit) begin
            if (!status.done) begin
              state <= S_IDLE;
            end else if (status.wrap) begin
              state      <= S_TYPE;
              hdr_to_pad <= 1'b1;
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (emit && status.pad_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pkrs_dp.sv
// Datapath of the PKCS#7 record segmenter: configuration registers, transfer
// counters, padding counter and the output register. Depends on pkrs_pkg.
`default_nettype none

module pkrs_dp
  import pkrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        s_op,
  input  wire logic [7:0]  s_data,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_byte,
  output logic             m_record_end,
  output logic             m_transfer_end,
  output logic             m_run_last
);

  logic [7:0]  type_byte;
  logic [12:0] transfer_length;
  logic [12:0] bytes_taken;
  logic [4:0]  offset_in_record;
  logic [7:0]  record_number;
  logic        busy;
  logic [7:0]  data_hold;
  logic [4:0]  pad_val;
  logic [4:0]  pad_left;

  logic [4:0]  off_inc;
  logic [12:0] taken_inc;
  logic        wrap;
  logic        done;
  logic        pad_last;
  logic [4:0]  fill;
  logic [7:0]  count_byte;

  // Step values for one payload byte
  assign off_inc    = offset_in_record + 5'd1;
  assign taken_inc  = bytes_taken + 13'd1;
  assign wrap       = (off_inc == BODY_BYTES);
  assign done       = (taken_inc >= transfer_length);
  assign pad_last   = (pad_left == 5'd1);
  assign fill       = BODY_BYTES - off_inc;
  assign count_byte = rec_count_of(transfer_length);

  always_comb begin
    status.busy        = busy;
    status.len_zero    = (transfer_length == 13'd0);
    status.offset_zero = (offset_in_record == 5'd0);
    status.done        = done;
    status.wrap        = wrap;
    status.pad_last    = pad_last;
    status.slot_free   = !m_tvalid || m_tready;
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      type_byte       <= 8'd0;
      transfer_length <= 13'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TYPE) type_byte <= cfg_wdata[7:0];
      else                       transfer_length <= cfg_wdata;
    end
  end

  // Advance transfer counters; clear them on the last padding byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_taken      <= 13'd0;
      offset_in_record <= 5'd0;
      record_number    <= 8'd0;
      busy             <= 1'b0;
    end else if (cmd.accept && s_op == OP_START) begin
      bytes_taken      <= 13'd0;
      offset_in_record <= 5'd0;
      record_number    <= 8'd0;
      busy             <= (transfer_length != 13'd0);
    end else if (cmd.emit && cmd.kind == EK_DATA) begin
      bytes_taken <= taken_inc;
      if (wrap) begin
        offset_in_record <= 5'd0;
        record_number    <= record_number + 8'd1;
      end else begin
        offset_in_record <= off_inc;
      end
    end else if (cmd.emit && cmd.kind == EK_PAD && pad_last) begin
      bytes_taken      <= 13'd0;
      offset_in_record <= 5'd0;
      record_number    <= 8'd0;
      busy             <= 1'b0;
    end
  end

  // Latch payload byte and padding plan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_hold <= s_data;
      pad_val   <= BODY_BYTES;
      pad_left  <= BODY_BYTES;
    end else if (cmd.emit && cmd.kind == EK_DATA) begin
      pad_val  <= wrap ? BODY_BYTES : fill;
      pad_left <= wrap ? BODY_BYTES : fill;
    end else if (cmd.emit && cmd.kind == EK_PAD) begin
      pad_left <= pad_left - 5'd1;
    end
  end

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_record_end   <= 1'b0;
      m_transfer_end <= 1'b0;
      m_run_last     <= 1'b0;
      case (cmd.kind)
        EK_TYPE:  m_byte <= type_byte;
        EK_COUNT: m_byte <= count_byte;
        EK_INDEX: m_byte <= record_number;
        EK_DATA: begin
          m_byte       <= data_hold;
          m_record_end <= wrap;
          m_run_last   <= !done;
        end
        EK_PAD: begin
          m_byte         <= {3'd0, pad_val};
          m_record_end   <= pad_last;
          m_transfer_end <= pad_last;
          m_run_last     <= pad_last;
        end
        default: m_byte <= type_byte;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pkcs7_record_segmenter.sv
// A payload byte is registered on the output after its request is taken, or after
// a record header; a final request adds up to 20 header/padding bytes.
// Each payload byte is taken, then emitted, before the next request is taken; other
// bytes go one per cycle, stalled by m_tready; the controller sequences one at a time.
// Reset (rst, synchronous): idle, counters and configuration registers zero, output empty.
// Top level of the PKCS#7 record segmenter; depends on pkrs_pkg, pkrs_ctrl, pkrs_dp.
`default_nettype none

module pkcs7_record_segmenter
  import pkrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic [1:0]       m_tuser,   // [0] record_end, [1] transfer_end
  output logic             m_tlast    // run_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pkrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pkrs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_op           (s_tuser),
    .s_data         (s_tdata),
    .cmd            (cmd),
    .status         (status),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_byte         (m_tdata),
    .m_record_end   (m_tuser[0]),
    .m_transfer_end (m_tuser[1]),
    .m_run_last     (m_tlast)
  );

endmodule

`default_nettype wire

### rtl/pkrs_checker.sv
// Port-level checks of the PKCS#7 record segmenter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module pkrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  // Output empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Stalled output request holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output changed");

  // Transfer end closes the record and the run
  a_end_marks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
    else $error("transfer end without record end and last");

  // No new request while a run is still being emitted
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a run");

endmodule

bind pkcs7_record_segmenter pkrs_checker u_pkrs_checker (.*);

`default_nettype wire
